@@ rtl/ffha_pkg.sv @@
package ffha_pkg;

   // Record pool geometry
   localparam int BLOCK_RECORDS = 2048;
   localparam int IDX_W         = $clog2(BLOCK_RECORDS);
   localparam int CNT_W         = $clog2(BLOCK_RECORDS + 1);

   // Alignment of granted blocks
   localparam int ALIGN_W   = 3;
   localparam int ALIGNMENT = 1 << ALIGN_W;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_IDX_W   = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_SIZE = 8'd1;

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_UNUSED = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_ALLOC  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOFIT    = 3'd1,
      ST_NOREC    = 3'd2,
      ST_ZERO     = 3'd3,
      ST_NOTALLOC = 3'd4
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] size;
      logic [31:0] base;
   } record_type;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CLEAR  = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_DRAIN  = 8'b0000_1000,
      S_DECIDE = 8'b0001_0000,
      S_BUILD  = 8'b0010_0000,
      S_WRITE  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic clear;
      logic scan;
      logic decide;
      logic build;
      logic write;
      logic load_rsp;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type in_op;
      logic   in_zero;
      logic   init_mode;
      logic   cnt_last;
      logic   wr_last;
      logic   rsp_busy;
   } dp_status_type;

endpackage

@@ rtl/ffha_ram.sv @@
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/ffha_ctrl.sv @@
module ffha_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ffha_pkg::dp_status_type stat,
   output ffha_pkg::ctl_cmd_type   cmd
);

   ffha_pkg::state_type state_ff, state_in;

   assign req_tready = (state_ff == ffha_pkg::S_IDLE);

   // Sequencer: sweep, scan, decide, write back, respond
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (stat.in_op)
                  ffha_pkg::OP_INIT:  state_in = ffha_pkg::S_CLEAR;
                  ffha_pkg::OP_ALLOC: state_in = stat.in_zero ? ffha_pkg::S_DONE
                                                              : ffha_pkg::S_SCAN;
                  ffha_pkg::OP_FREE:  state_in = ffha_pkg::S_SCAN;
                  default:            state_in = ffha_pkg::S_DONE;
               endcase
            end
         end
         ffha_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.cnt_last) begin
               state_in = stat.init_mode ? ffha_pkg::S_DONE : ffha_pkg::S_IDLE;
            end
         end
         ffha_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.cnt_last) begin
               state_in = ffha_pkg::S_DRAIN;
            end
         end
         ffha_pkg::S_DRAIN: begin
            state_in = ffha_pkg::S_DECIDE;
         end
         ffha_pkg::S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ffha_pkg::S_BUILD;
         end
         ffha_pkg::S_BUILD: begin
            cmd.build = 1'b1;
            state_in  = ffha_pkg::S_WRITE;
         end
         ffha_pkg::S_WRITE: begin
            cmd.write = 1'b1;
            if (stat.wr_last) begin
               state_in = ffha_pkg::S_DONE;
            end
         end
         ffha_pkg::S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ffha_pkg::S_IDLE;
            end
         end
         default: state_in = ffha_pkg::S_IDLE;
      endcase
   end

   // Reset starts with a sweep of the pool
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/ffha_dpath.sv @@
module ffha_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  ffha_pkg::ctl_cmd_type               cmd,
   output ffha_pkg::dp_status_type             stat,
   input  logic [ffha_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                csr_valid,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ffha_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int IW = ffha_pkg::IDX_W;
   localparam int CW = ffha_pkg::CNT_W;

   typedef struct packed {
      logic                          pick_v;
      logic [IW-1:0]                 pick_idx;
      logic [31:0]                   pick_base;
      logic [31:0]                   pick_base1;
      logic [31:0]                   pick_size1;
      logic [ffha_pkg::ALIGN_W-1:0]  pick_skip;
      logic                          u0_v;
      logic [IW-1:0]                 u0;
      logic                          u1_v;
      logic [IW-1:0]                 u1;
      logic                          blk_v;
      logic [IW-1:0]                 blk_idx;
      logic [31:0]                   blk_size;
      logic                          prev_v;
      logic [IW-1:0]                 prev_idx;
      logic [31:0]                   prev_base;
      logic [31:0]                   prev_size;
      logic                          next_v;
      logic [IW-1:0]                 next_idx;
      logic [31:0]                   next_base;
      logic [31:0]                   next_size;
   } track_type;

   typedef struct packed {
      logic                 v;
      logic [IW-1:0]        idx;
      ffha_pkg::record_type rec;
   } wslot_type;

   // Request fields
   ffha_pkg::op_type in_op;
   logic [31:0]      in_size;
   logic [31:0]      in_addr;

   // Registers
   ffha_pkg::op_type     op_ff, op_in;
   logic [31:0]          size_ff, size_in;
   logic [31:0]          addr_ff, addr_in;
   logic                 init_mode_ff, init_mode_in;
   logic [31:0]          heap_base_ff, heap_base_in;
   logic [31:0]          heap_size_ff, heap_size_in;
   logic [IW-1:0]        cnt_ff, cnt_in;
   logic [1:0]           wstep_ff, wstep_in;
   logic                 rd_v_ff, rd_v_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   track_type            trk_ff, trk_in;
   logic                 mnext_ff, mnext_in;
   logic                 mprev_ff, mprev_in;
   logic [31:0]          bsize_ff, bsize_in;
   wslot_type            slot_ff [3];
   wslot_type            slot_in [3];
   logic [CW-1:0]        unused_ff, unused_in;
   logic [31:0]          used_ff, used_in;
   logic [31:0]          res_addr_ff, res_addr_in;
   ffha_pkg::status_type res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory side
   logic                 ram_we;
   logic [IW-1:0]        ram_waddr;
   ffha_pkg::record_type ram_wdata;
   ffha_pkg::record_type clr_rec;
   logic [$bits(ffha_pkg::record_type)-1:0] ram_rdata;
   ffha_pkg::record_type rec;

   // Scan evaluation
   logic [ffha_pkg::ALIGN_W-1:0] skip;
   logic                         fit;
   logic                         cnt_last;

   // Build terms
   logic       rem;
   logic [1:0] need;
   logic [31:0] end_blk;

   assign in_op   = ffha_pkg::op_type'(req_tdata[1:0]);
   assign in_size = req_tdata[33:2];
   assign in_addr = req_tdata[65:34];

   assign cnt_last = (cnt_ff == IW'(ffha_pkg::BLOCK_RECORDS - 1));

   assign stat.in_op     = in_op;
   assign stat.in_zero   = (in_size == 32'd0);
   assign stat.init_mode = init_mode_ff;
   assign stat.cnt_last  = cnt_last;
   assign stat.wr_last   = (wstep_ff == 2'd2);
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_tready;

   // Record pool
   always_comb begin
      clr_rec.kind = (init_mode_ff && cnt_ff == '0) ? ffha_pkg::KIND_FREE
                                                    : ffha_pkg::KIND_UNUSED;
      clr_rec.base = heap_base_ff;
      clr_rec.size = heap_size_ff;
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = cnt_ff;
         ram_wdata = clr_rec;
      end else begin
         ram_we    = cmd.write && slot_ff[wstep_ff].v;
         ram_waddr = slot_ff[wstep_ff].idx;
         ram_wdata = slot_ff[wstep_ff].rec;
      end
   end

   ffha_ram #(
      .WIDTH ($bits(ffha_pkg::record_type)),
      .DEPTH (ffha_pkg::BLOCK_RECORDS)
   ) u_pool (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cnt_ff),
      .rdata (ram_rdata)
   );

   assign rec  = ffha_pkg::record_type'(ram_rdata);
   assign skip = ffha_pkg::ALIGN_W'(3'd0 - rec.base[ffha_pkg::ALIGN_W-1:0]);
   assign fit  = ({30'd0, skip} + {1'b0, size_ff}) <= {1'b0, rec.size};

   // Configuration registers
   always_comb begin
      heap_base_in = heap_base_ff;
      heap_size_in = heap_size_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ffha_pkg::CSR_HEAP_BASE: heap_base_in = csr_data;
            ffha_pkg::CSR_HEAP_SIZE: heap_size_in = csr_data;
            default: ;
         endcase
      end
   end

   // Request latch, counters
   always_comb begin
      op_in        = op_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      init_mode_in = init_mode_ff;
      cnt_in       = cnt_ff;
      wstep_in     = wstep_ff;
      if (cmd.accept) begin
         op_in        = in_op;
         size_in      = (in_size < 32'(ffha_pkg::ALIGNMENT)) ?
                        32'(ffha_pkg::ALIGNMENT) : in_size;
         addr_in      = in_addr;
         init_mode_in = (in_op == ffha_pkg::OP_INIT);
         cnt_in       = '0;
      end else if (cmd.clear || cmd.scan) begin
         cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
      end
      if (cmd.build) begin
         wstep_in = 2'd0;
      end else if (cmd.write) begin
         wstep_in = wstep_ff + 2'd1;
      end
      rd_v_in   = cmd.scan;
      rd_idx_in = cnt_ff;
   end

   // Scan trackers: first fit, free neighbors, first two unused records
   always_comb begin
      trk_in = trk_ff;
      if (cmd.accept) begin
         trk_in.pick_v = 1'b0;
         trk_in.u0_v   = 1'b0;
         trk_in.u1_v   = 1'b0;
         trk_in.blk_v  = 1'b0;
         trk_in.prev_v = 1'b0;
         trk_in.next_v = 1'b0;
      end else if (rd_v_ff) begin
         if (rec.kind == ffha_pkg::KIND_FREE && fit &&
             (!trk_ff.pick_v || rec.base < trk_ff.pick_base)) begin
            trk_in.pick_v     = 1'b1;
            trk_in.pick_idx   = rd_idx_ff;
            trk_in.pick_base  = rec.base;
            trk_in.pick_base1 = rec.base + 32'(skip);
            trk_in.pick_size1 = rec.size - 32'(skip);
            trk_in.pick_skip  = skip;
         end
         if (rec.kind == ffha_pkg::KIND_UNUSED) begin
            if (!trk_ff.u0_v) begin
               trk_in.u0_v = 1'b1;
               trk_in.u0   = rd_idx_ff;
            end else if (!trk_ff.u1_v) begin
               trk_in.u1_v = 1'b1;
               trk_in.u1   = rd_idx_ff;
            end
         end
         if (rec.kind == ffha_pkg::KIND_ALLOC && rec.base == addr_ff && !trk_ff.blk_v) begin
            trk_in.blk_v    = 1'b1;
            trk_in.blk_idx  = rd_idx_ff;
            trk_in.blk_size = rec.size;
         end
         if (rec.kind == ffha_pkg::KIND_FREE) begin
            if (rec.base < addr_ff) begin
               if (!trk_ff.prev_v || rec.base > trk_ff.prev_base) begin
                  trk_in.prev_v    = 1'b1;
                  trk_in.prev_idx  = rd_idx_ff;
                  trk_in.prev_base = rec.base;
                  trk_in.prev_size = rec.size;
               end
            end else if (!trk_ff.next_v || rec.base < trk_ff.next_base) begin
               trk_in.next_v    = 1'b1;
               trk_in.next_idx  = rd_idx_ff;
               trk_in.next_base = rec.base;
               trk_in.next_size = rec.size;
            end
         end
      end
   end

   // Merge tests for free
   assign end_blk = addr_ff + trk_ff.blk_size;

   always_comb begin
      mnext_in = mnext_ff;
      mprev_in = mprev_ff;
      bsize_in = bsize_ff;
      if (cmd.decide) begin
         mnext_in = trk_ff.next_v && (end_blk == trk_ff.next_base);
         mprev_in = trk_ff.prev_v && (trk_ff.prev_base + trk_ff.prev_size == addr_ff);
         bsize_in = trk_ff.blk_size + (mnext_in ? trk_ff.next_size : 32'd0);
      end
   end

   // Outcome and write-back slots
   assign rem  = (trk_ff.pick_size1 != size_ff);
   assign need = {1'b0, trk_ff.pick_skip != '0} + {1'b0, rem};

   always_comb begin
      slot_in       = slot_ff;
      unused_in     = unused_ff;
      used_in       = used_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      if (cmd.accept) begin
         res_addr_in   = 32'd0;
         res_status_in = (in_op == ffha_pkg::OP_ALLOC && in_size == 32'd0) ?
                         ffha_pkg::ST_ZERO : ffha_pkg::ST_OK;
         if (in_op == ffha_pkg::OP_INIT) begin
            used_in = 32'd0;
         end
      end
      if (cmd.clear && cnt_last) begin
         unused_in = CW'(ffha_pkg::BLOCK_RECORDS) - CW'(init_mode_ff);
      end
      if (cmd.build) begin
         for (int k = 0; k < 3; k++) begin
            slot_in[k].v = 1'b0;
         end
         if (op_ff == ffha_pkg::OP_ALLOC) begin
            if (!trk_ff.pick_v) begin
               res_status_in = ffha_pkg::ST_NOFIT;
            end else if (unused_ff < CW'(need)) begin
               res_status_in = ffha_pkg::ST_NOREC;
            end else begin
               // alignment skip
               slot_in[0].v        = (trk_ff.pick_skip != '0);
               slot_in[0].idx      = trk_ff.u0;
               slot_in[0].rec.kind = ffha_pkg::KIND_FREE;
               slot_in[0].rec.base = trk_ff.pick_base;
               slot_in[0].rec.size = 32'(trk_ff.pick_skip);
               // remainder
               slot_in[1].v        = rem;
               slot_in[1].idx      = (trk_ff.pick_skip != '0) ? trk_ff.u1 : trk_ff.u0;
               slot_in[1].rec.kind = ffha_pkg::KIND_FREE;
               slot_in[1].rec.base = trk_ff.pick_base1 + size_ff;
               slot_in[1].rec.size = trk_ff.pick_size1 - size_ff;
               // granted block
               slot_in[2].v        = 1'b1;
               slot_in[2].idx      = trk_ff.pick_idx;
               slot_in[2].rec.kind = ffha_pkg::KIND_ALLOC;
               slot_in[2].rec.base = trk_ff.pick_base1;
               slot_in[2].rec.size = size_ff;
               res_status_in = ffha_pkg::ST_OK;
               res_addr_in   = trk_ff.pick_base1;
               used_in       = used_ff + size_ff;
               unused_in     = unused_ff - CW'(need);
            end
         end else begin
            if (!trk_ff.blk_v) begin
               res_status_in = ffha_pkg::ST_NOTALLOC;
            end else begin
               // absorbed upper neighbor
               slot_in[0].v        = mnext_ff;
               slot_in[0].idx      = trk_ff.next_idx;
               slot_in[0].rec.kind = ffha_pkg::KIND_UNUSED;
               slot_in[0].rec.base = trk_ff.next_base;
               slot_in[0].rec.size = trk_ff.next_size;
               // released block, dropped if absorbed below
               slot_in[1].v        = 1'b1;
               slot_in[1].idx      = trk_ff.blk_idx;
               slot_in[1].rec.kind = mprev_ff ? ffha_pkg::KIND_UNUSED : ffha_pkg::KIND_FREE;
               slot_in[1].rec.base = addr_ff;
               slot_in[1].rec.size = bsize_ff;
               // lower neighbor grows
               slot_in[2].v        = mprev_ff;
               slot_in[2].idx      = trk_ff.prev_idx;
               slot_in[2].rec.kind = ffha_pkg::KIND_FREE;
               slot_in[2].rec.base = trk_ff.prev_base;
               slot_in[2].rec.size = trk_ff.prev_size + bsize_ff;
               res_status_in = ffha_pkg::ST_OK;
               used_in       = used_ff - trk_ff.blk_size;
               unused_in     = unused_ff + CW'(mnext_ff) + CW'(mprev_ff);
            end
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, used_ff, res_status_ff, res_addr_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Control state, trackers and write slots
   always_ff @(posedge clock) begin
      trk_ff.pick_idx   <= trk_in.pick_idx;
      trk_ff.pick_base  <= trk_in.pick_base;
      trk_ff.pick_base1 <= trk_in.pick_base1;
      trk_ff.pick_size1 <= trk_in.pick_size1;
      trk_ff.pick_skip  <= trk_in.pick_skip;
      trk_ff.u0         <= trk_in.u0;
      trk_ff.u1         <= trk_in.u1;
      trk_ff.blk_idx    <= trk_in.blk_idx;
      trk_ff.blk_size   <= trk_in.blk_size;
      trk_ff.prev_idx   <= trk_in.prev_idx;
      trk_ff.prev_base  <= trk_in.prev_base;
      trk_ff.prev_size  <= trk_in.prev_size;
      trk_ff.next_idx   <= trk_in.next_idx;
      trk_ff.next_base  <= trk_in.next_base;
      trk_ff.next_size  <= trk_in.next_size;
      for (int k = 0; k < 3; k++) begin
         slot_ff[k].idx <= slot_in[k].idx;
         slot_ff[k].rec <= slot_in[k].rec;
      end
      if (reset) begin
         init_mode_ff <= 1'b0;
         heap_base_ff <= 32'd0;
         heap_size_ff <= 32'd0;
         cnt_ff       <= '0;
         wstep_ff     <= 2'd0;
         rd_v_ff      <= 1'b0;
         unused_ff    <= '0;
         used_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
         trk_ff.pick_v <= 1'b0;
         trk_ff.u0_v   <= 1'b0;
         trk_ff.u1_v   <= 1'b0;
         trk_ff.blk_v  <= 1'b0;
         trk_ff.prev_v <= 1'b0;
         trk_ff.next_v <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            slot_ff[k].v <= 1'b0;
         end
      end else begin
         init_mode_ff <= init_mode_in;
         heap_base_ff <= heap_base_in;
         heap_size_ff <= heap_size_in;
         cnt_ff       <= cnt_in;
         wstep_ff     <= wstep_in;
         rd_v_ff      <= rd_v_in;
         unused_ff    <= unused_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         trk_ff.pick_v <= trk_in.pick_v;
         trk_ff.u0_v   <= trk_in.u0_v;
         trk_ff.u1_v   <= trk_in.u1_v;
         trk_ff.blk_v  <= trk_in.blk_v;
         trk_ff.prev_v <= trk_in.prev_v;
         trk_ff.next_v <= trk_in.next_v;
         for (int k = 0; k < 3; k++) begin
            slot_ff[k].v <= slot_in[k].v;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      mnext_ff      <= mnext_in;
      mprev_ff      <= mprev_in;
      bsize_ff      <= bsize_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator with coalescing over a pool of 2048 block records
// kept in one single-port-write, registered-read RAM. Every transaction returns
// exactly one response. Allocate and free each sweep the whole record table once,
// one record per cycle through the RAM read port, then drain the read, decide,
// build and step through three write-back slots, and load the response. Init
// rewrites every record, one per cycle; a zero-size allocate and operation 3 go
// straight from acceptance to loading the response. A response that is not taken
// holds the next transaction in its final state until it is. After reset the
// block runs a clearing pass over every record before it accepts its first
// transaction; register writes are taken at any time. Set heap_base and
// heap_size, then send init.
module first_fit_heap_allocator (
   input  logic                              clock,
   input  logic                              reset,
   // request: [1:0] operation, [33:2] request_size, [65:34] free_address
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ffha_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response: [31:0] granted_address, [34:32] status, [66:35] bytes_in_use
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ffha_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // register writes: 0 heap_base, 1 heap_size
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_data
);

   ffha_pkg::ctl_cmd_type   cmd;
   ffha_pkg::dp_status_type stat;

   assign csr_ready = 1'b1;

   ffha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffha_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // An accepted transaction always takes the controller out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted request left the controller idle");

   // Status codes stay within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:32] <= 3'(ffha_pkg::ST_NOTALLOC)))
      else $error("response status out of range");

   // A failed transaction grants no address
   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[34:32] != 3'(ffha_pkg::ST_OK)) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("failed response carries an address");

endmodule

@@ tb/sv/first_fit_heap_allocator_tb.sv @@
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

   localparam int NO_REC = -1;

   typedef struct {
      ffha_pkg::op_type op;
      logic [31:0]      req_size;
      logic [31:0]      free_addr;
   } heap_req_type;

   typedef struct {
      logic [31:0]          granted;
      ffha_pkg::status_type status;
      logic [31:0]          in_use;
   } heap_rsp_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ffha_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ffha_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ffha_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [31:0]                      csr_data = '0;

   first_fit_heap_allocator uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow heap state
   logic [31:0]        sh_base [ffha_pkg::BLOCK_RECORDS];
   logic [31:0]        sh_size [ffha_pkg::BLOCK_RECORDS];
   ffha_pkg::kind_type sh_kind [ffha_pkg::BLOCK_RECORDS];
   logic [31:0] sh_used = '0;
   logic [31:0] cfg_base = '0;
   logic [31:0] cfg_size = '0;

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   logic [31:0]  live_blocks[$];
   int           pushed_cnt = 0;
   int           accepted_cnt = 0;
   int           errors = 0;
   bit           no_gaps = 0;

   initial foreach (sh_kind[i]) sh_kind[i] = ffha_pkg::KIND_UNUSED;

   function automatic int first_unused();
      foreach (sh_kind[i]) if (sh_kind[i] == ffha_pkg::KIND_UNUSED) return i;
      return NO_REC;
   endfunction

   function automatic heap_rsp_type heap_apply(heap_req_type r);
      heap_rsp_type o;
      int           pick, blk, prv, nxt, idx, unused_n, need;
      logic [31:0]  sz, skip, s;
      o.granted = '0;
      o.status  = ffha_pkg::ST_OK;
      case (r.op)
         ffha_pkg::OP_INIT: begin
            foreach (sh_kind[i]) sh_kind[i] = ffha_pkg::KIND_UNUSED;
            sh_kind[0] = ffha_pkg::KIND_FREE;
            sh_base[0] = cfg_base;
            sh_size[0] = cfg_size;
            sh_used = '0;
            live_blocks.delete();
         end
         ffha_pkg::OP_ALLOC: begin
            sz = r.req_size;
            if (sz == 0) o.status = ffha_pkg::ST_ZERO;
            else begin
               if (sz < ffha_pkg::ALIGNMENT) sz = ffha_pkg::ALIGNMENT;
               pick = NO_REC;
               skip = '0;
               foreach (sh_kind[i]) begin
                  if (sh_kind[i] != ffha_pkg::KIND_FREE) continue;
                  s = (32'd0 - sh_base[i]) & (ffha_pkg::ALIGNMENT - 1);
                  if ({32'd0, s} + {32'd0, sz} > {32'd0, sh_size[i]}) continue;
                  if (pick == NO_REC || sh_base[i] < sh_base[pick]) begin
                     pick = i;
                     skip = s;
                  end
               end
               if (pick == NO_REC) o.status = ffha_pkg::ST_NOFIT;
               else begin
                  need = (skip != 0) + (skip + sz != sh_size[pick]);
                  unused_n = 0;
                  foreach (sh_kind[i]) if (sh_kind[i] == ffha_pkg::KIND_UNUSED) unused_n++;
                  if (unused_n < need) o.status = ffha_pkg::ST_NOREC;
                  else begin
                     // split off alignment skip, then the tail
                     if (skip != 0) begin
                        idx = first_unused();
                        sh_kind[idx] = ffha_pkg::KIND_FREE;
                        sh_base[idx] = sh_base[pick];
                        sh_size[idx] = skip;
                        sh_base[pick] += skip;
                        sh_size[pick] -= skip;
                     end
                     if (sz != sh_size[pick]) begin
                        idx = first_unused();
                        sh_kind[idx] = ffha_pkg::KIND_FREE;
                        sh_base[idx] = sh_base[pick] + sz;
                        sh_size[idx] = sh_size[pick] - sz;
                        sh_size[pick] = sz;
                     end
                     sh_kind[pick] = ffha_pkg::KIND_ALLOC;
                     sh_used += sz;
                     o.granted = sh_base[pick];
                     live_blocks.push_back(o.granted);
                  end
               end
            end
         end
         ffha_pkg::OP_FREE: begin
            blk = NO_REC;
            foreach (sh_kind[i])
               if (blk == NO_REC && sh_kind[i] == ffha_pkg::KIND_ALLOC &&
                   sh_base[i] == r.free_addr)
                  blk = i;
            if (blk == NO_REC) o.status = ffha_pkg::ST_NOTALLOC;
            else begin
               sh_used -= sh_size[blk];
               sh_kind[blk] = ffha_pkg::KIND_FREE;
               foreach (live_blocks[j])
                  if (live_blocks[j] == r.free_addr) begin
                     live_blocks.delete(j);
                     break;
                  end
               prv = NO_REC;
               nxt = NO_REC;
               foreach (sh_kind[i]) begin
                  if (i == blk || sh_kind[i] != ffha_pkg::KIND_FREE) continue;
                  if (sh_base[i] < r.free_addr) begin
                     if (prv == NO_REC || sh_base[i] > sh_base[prv]) prv = i;
                  end else begin
                     if (nxt == NO_REC || sh_base[i] < sh_base[nxt]) nxt = i;
                  end
               end
               // coalesce with neighbors
               if (nxt != NO_REC && sh_base[blk] + sh_size[blk] == sh_base[nxt]) begin
                  sh_size[blk] += sh_size[nxt];
                  sh_kind[nxt] = ffha_pkg::KIND_UNUSED;
               end
               if (prv != NO_REC && sh_base[prv] + sh_size[prv] == sh_base[blk]) begin
                  sh_size[prv] += sh_size[blk];
                  sh_kind[blk] = ffha_pkg::KIND_UNUSED;
               end
            end
         end
         default: ;
      endcase
      o.in_use = sh_used;
      return o;
   endfunction

   // Request driver
   bit req_taken = 0;
   int req_gap = 0;

   function automatic int pick_gap();
      if (no_gaps) return 0;
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
   endfunction

   always @(negedge clock) begin
      heap_req_type r;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_taken) req_gap = pick_gap();
         if (req_gap > 0 || pending_reqs.size() == 0) begin
            req_tvalid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end else begin
            r = pending_reqs.pop_front();
            req_tdata  <= {6'd0, r.free_addr, r.req_size, r.op};
            req_tvalid <= 1'b1;
         end
      end
   end

   // Response ready with random stalls
   int rsp_stall = 0;
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // Accept requests and predict; check responses
   always @(posedge clock) begin
      heap_req_type r;
      heap_rsp_type e, a;
      req_taken = req_tvalid && req_tready;
      if (req_taken) begin
         r.op        = ffha_pkg::op_type'(req_tdata[1:0]);
         r.req_size  = req_tdata[33:2];
         r.free_addr = req_tdata[65:34];
         expected_rsps.push_back(heap_apply(r));
         accepted_cnt++;
      end
      if (rsp_tvalid && rsp_tready) begin
         a.granted = rsp_tdata[31:0];
         a.status  = ffha_pkg::status_type'(rsp_tdata[34:32]);
         a.in_use  = rsp_tdata[66:35];
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response granted=%h status=%0d in_use=%h",
                     $time, a.granted, a.status, a.in_use);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (a.granted !== e.granted) begin
               $display("%0t: granted_address expected %h actual %h", $time, e.granted, a.granted);
               errors++;
            end
            if (a.status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
               errors++;
            end
            if (a.in_use !== e.in_use) begin
               $display("%0t: bytes_in_use expected %h actual %h", $time, e.in_use, a.in_use);
               errors++;
            end
         end
      end
   end

   task automatic send(ffha_pkg::op_type op, logic [31:0] sz, logic [31:0] addr);
      heap_req_type r;
      r.op = op;
      r.req_size = sz;
      r.free_addr = addr;
      pending_reqs.push_back(r);
      pushed_cnt++;
   endtask

   task automatic wait_idle();
      wait (accepted_cnt == pushed_cnt && expected_rsps.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [ffha_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == ffha_pkg::CSR_HEAP_BASE) cfg_base = val;
      else if (idx == ffha_pkg::CSR_HEAP_SIZE) cfg_size = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_size();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return 32'd0;
      if (k == 1) return $urandom();
      if (k == 2) return 32'hFFFF_FFFF;
      if (k < 6) return $urandom_range(1, 7);
      if (k < 9) return $urandom_range(1, 4096);
      return $urandom_range(8, 200);
   endfunction

   // Random traffic: mostly alloc/free of live blocks, some noise
   task automatic random_traffic(int n);
      int k;
      repeat (n) begin
         wait (pending_reqs.size() == 0);
         k = $urandom_range(0, 99);
         if (k < 50) send(ffha_pkg::OP_ALLOC, rand_size(), $urandom());
         else if (k < 85 && live_blocks.size() > 0)
            send(ffha_pkg::OP_FREE, $urandom(),
                 live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
         else if (k < 93) send(ffha_pkg::OP_FREE, $urandom(), $urandom());
         else if (k < 97) send(ffha_pkg::OP_NOP, $urandom(), $urandom());
         else send(ffha_pkg::OP_INIT, $urandom(), $urandom());
      end
   endtask

   typedef struct {
      logic [31:0] b;
      logic [31:0] s;
   } region_type;

   initial begin
      region_type regions[6];
      regions[0] = '{32'h0000_0000, 32'h0000_4000};
      regions[1] = '{32'h0000_1003, 32'h0000_2000};
      regions[2] = '{32'hFFFF_F001, 32'h0000_1000};
      regions[3] = '{32'h0000_0000, 32'hFFFF_FFFF};
      regions[4] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};
      regions[5] = '{32'h8000_0005, 32'h0000_0800};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: before init, then an empty region
      send(ffha_pkg::OP_ALLOC, 32'd16, 32'd0);
      send(ffha_pkg::OP_FREE, 32'd0, 32'd0);
      send(ffha_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();
      csr_write(ffha_pkg::CSR_HEAP_BASE, 32'h0000_0000);
      csr_write(ffha_pkg::CSR_HEAP_SIZE, 32'h0000_0000);
      send(ffha_pkg::OP_INIT, 32'd0, 32'd0);
      send(ffha_pkg::OP_ALLOC, 32'd1, 32'd0);
      wait_idle();

      // Directed on a small aligned region at address zero
      csr_write(ffha_pkg::CSR_HEAP_SIZE, 32'h0000_0100);
      send(ffha_pkg::OP_INIT, 32'd0, 32'd0);
      send(ffha_pkg::OP_ALLOC, 32'd0, 32'd0);
      send(ffha_pkg::OP_ALLOC, 32'd1, 32'd0);
      send(ffha_pkg::OP_ALLOC, 32'd7, 32'd0);
      send(ffha_pkg::OP_ALLOC, 32'd13, 32'd0);
      send(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
      send(ffha_pkg::OP_ALLOC, 32'hFFFF_FFF8, 32'd0);
      send(ffha_pkg::OP_FREE, 32'd0, 32'd8);
      send(ffha_pkg::OP_FREE, 32'd0, 32'd0);
      send(ffha_pkg::OP_FREE, 32'd0, 32'd0);
      send(ffha_pkg::OP_FREE, 32'd0, 32'd16);
      send(ffha_pkg::OP_ALLOC, 32'd232, 32'd0);
      send(ffha_pkg::OP_ALLOC, 32'd24, 32'd0);
      send(ffha_pkg::OP_FREE, 32'd0, 32'hFFFF_FFFF);
      wait_idle();

      // Random phases over several regions, one without idling
      foreach (regions[p]) begin
         no_gaps = (p == 3);
         csr_write(ffha_pkg::CSR_HEAP_BASE, regions[p].b);
         csr_write(ffha_pkg::CSR_HEAP_SIZE, regions[p].s);
         send(ffha_pkg::OP_INIT, 32'd0, 32'd0);
         random_traffic(45);
         wait_idle();
      end

      wait (expected_rsps.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
